>>> src/miq_pkg.sv
// Shared types, constants and ring arithmetic for the middle-insert queue.
package miq_pkg;

    localparam int CAP    = 256;
    localparam int IDX_W  = $clog2(CAP);
    localparam int CNT_W  = $clog2(CAP + 1);
    localparam int DATA_W = 32;

    localparam logic [1:0] OP_PUSH_TAIL = 2'd0;
    localparam logic [1:0] OP_PUSH_MID  = 2'd1;
    localparam logic [1:0] OP_POP       = 2'd2;
    localparam logic [1:0] OP_NONE      = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [DATA_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic [1:0]               status;
    } result_t;

    // One RAM's request for the current cycle
    typedef struct packed {
        logic              re;
        logic [IDX_W-1:0]  raddr;
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
    } ram_req_t;

    // Work left for an item once its reads are issued
    typedef struct packed {
        logic              has_res;
        logic [1:0]        status;
        logic              res_mem;
        logic              fr_we;
        logic [IDX_W-1:0]  fr_waddr;
        logic              fr_from_bk;
        logic              bk_we;
        logic [IDX_W-1:0]  bk_waddr;
        logic [DATA_W-1:0] value;
        logic              fwd_fr;
        logic              fwd_bk;
    } exec_t;

    typedef struct packed {
        logic [CNT_W-1:0] front;
        logic [CNT_W-1:0] back;
    } fill_t;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] head,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(CAP))
        begin
            sum = sum - (CNT_W + 1)'(CAP);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

>>> src/miq_ram.sv
// Simple dual-port RAM with registered read data.
module miq_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/miq_ctrl.sv
// Queue control: head and count registers, RAM requests, write-back and forwarding.
module miq_ctrl
    import miq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  item_t             item,
    input  logic              res_ready,
    output logic              res_valid,
    output result_t           res,
    output ram_req_t          fr_req,
    output ram_req_t          bk_req,
    input  logic [DATA_W-1:0] fr_rdata,
    input  logic [DATA_W-1:0] bk_rdata,
    output fill_t             fill
);

    logic [IDX_W-1:0]  fh_reg, fh_next, bh_reg, bh_next;
    logic [CNT_W-1:0]  fc_reg, fc_next, bc_reg, bc_next;
    logic              sb_valid_reg, sb_valid_next;
    exec_t             sb_reg, sb_next;
    logic [DATA_W-1:0] fwd_fr_data_reg, fwd_bk_data_reg;

    logic              accept, sb_hold, sb_fire, full;
    logic [CNT_W:0]    total;
    logic              fr_re, bk_re;
    logic [DATA_W-1:0] fr_rd_eff, bk_rd_eff, fr_wdata;

    // Write-back: finish the item whose reads were issued last time
    assign fr_rd_eff = sb_reg.fwd_fr ? fwd_fr_data_reg : fr_rdata;
    assign bk_rd_eff = sb_reg.fwd_bk ? fwd_bk_data_reg : bk_rdata;
    assign fr_wdata  = sb_reg.fr_from_bk ? bk_rd_eff : sb_reg.value;

    assign sb_hold    = sb_valid_reg && sb_reg.has_res && !res_ready;
    assign sb_fire    = sb_valid_reg && !sb_hold;
    assign item_stall = sb_hold;
    assign accept     = item_valid && !sb_hold;

    assign res_valid        = sb_fire && sb_reg.has_res;
    assign res.popped_value = sb_reg.res_mem ? fr_rd_eff : '0;
    assign res.status       = sb_reg.status;

    assign fr_req.re    = fr_re;
    assign fr_req.raddr = fh_reg;
    assign fr_req.we    = sb_fire && sb_reg.fr_we;
    assign fr_req.waddr = sb_reg.fr_waddr;
    assign fr_req.wdata = fr_wdata;

    assign bk_req.re    = bk_re;
    assign bk_req.raddr = bh_reg;
    assign bk_req.we    = sb_fire && sb_reg.bk_we;
    assign bk_req.waddr = sb_reg.bk_waddr;
    assign bk_req.wdata = sb_reg.value;

    assign fill.front = fc_reg;
    assign fill.back  = bc_reg;

    assign total = (CNT_W + 1)'(fc_reg) + (CNT_W + 1)'(bc_reg);
    assign full  = total >= (CNT_W + 1)'(CAP);

    // Issue: decide the moves, update heads and counts, issue reads
    always_comb
    begin
        fh_next = fh_reg;
        bh_next = bh_reg;
        fc_next = fc_reg;
        bc_next = bc_reg;
        fr_re   = 1'b0;
        bk_re   = 1'b0;
        sb_next = '0;
        sb_next.value = item.value;

        case (item.opcode)
            OP_PUSH_TAIL:
            begin
                if (full)
                begin
                    sb_next.has_res = 1'b1;
                    sb_next.status  = ST_FULL;
                end
                else if (fc_reg == bc_reg)
                begin
                    // back grows past front: its head moves to the front tail
                    sb_next.fr_we    = 1'b1;
                    sb_next.fr_waddr = ring_add(fh_reg, fc_reg);
                    fc_next          = fc_reg + 1'b1;
                    if (bc_reg != '0)
                    begin
                        bk_re              = 1'b1;
                        sb_next.fr_from_bk = 1'b1;
                        sb_next.bk_we      = 1'b1;
                        sb_next.bk_waddr   = ring_add(bh_reg, bc_reg);
                        bh_next            = ring_add(bh_reg, CNT_W'(1));
                    end
                end
                else
                begin
                    sb_next.bk_we    = 1'b1;
                    sb_next.bk_waddr = ring_add(bh_reg, bc_reg);
                    bc_next          = bc_reg + 1'b1;
                end
            end
            OP_PUSH_MID:
            begin
                if (full)
                begin
                    sb_next.has_res = 1'b1;
                    sb_next.status  = ST_FULL;
                end
                else if (fc_reg != bc_reg)
                begin
                    // front would be two ahead: the new value goes straight to the back head
                    sb_next.bk_we    = 1'b1;
                    sb_next.bk_waddr = ring_add(bh_reg, CNT_W'(CAP - 1));
                    bh_next          = ring_add(bh_reg, CNT_W'(CAP - 1));
                    bc_next          = bc_reg + 1'b1;
                end
                else
                begin
                    sb_next.fr_we    = 1'b1;
                    sb_next.fr_waddr = ring_add(fh_reg, fc_reg);
                    fc_next          = fc_reg + 1'b1;
                end
            end
            OP_POP:
            begin
                sb_next.has_res = 1'b1;
                if (fc_reg == '0)
                begin
                    sb_next.status = ST_EMPTY;
                end
                else
                begin
                    fr_re           = 1'b1;
                    sb_next.res_mem = 1'b1;
                    sb_next.status  = ST_OK;
                    fh_next         = ring_add(fh_reg, CNT_W'(1));
                    if (fc_reg == bc_reg)
                    begin
                        bk_re              = 1'b1;
                        sb_next.fr_we      = 1'b1;
                        sb_next.fr_waddr   = ring_add(fh_reg, fc_reg);
                        sb_next.fr_from_bk = 1'b1;
                        bh_next            = ring_add(bh_reg, CNT_W'(1));
                        bc_next            = bc_reg - 1'b1;
                    end
                    else
                    begin
                        fc_next = fc_reg - 1'b1;
                    end
                end
            end
            OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase

        if (!accept)
        begin
            fh_next = fh_reg;
            bh_next = bh_reg;
            fc_next = fc_reg;
            bc_next = bc_reg;
            fr_re   = 1'b0;
            bk_re   = 1'b0;
        end

        // a read of an entry written this very cycle takes the write data instead
        sb_next.fwd_fr = fr_re && fr_req.we && (fr_req.waddr == fh_reg);
        sb_next.fwd_bk = bk_re && bk_req.we && (bk_req.waddr == bh_reg);
    end

    assign sb_valid_next = accept || sb_hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fh_reg       <= '0;
            bh_reg       <= '0;
            fc_reg       <= '0;
            bc_reg       <= '0;
            sb_valid_reg <= 1'b0;
        end
        else
        begin
            fh_reg       <= fh_next;
            bh_reg       <= bh_next;
            fc_reg       <= fc_next;
            bc_reg       <= bc_next;
            sb_valid_reg <= sb_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sb_reg          <= sb_next;
            fwd_fr_data_reg <= fr_wdata;
            fwd_bk_data_reg <= sb_reg.value;
        end
    end

endmodule

>>> src/middle_insert_queue_unit.sv
// Top level of the middle-insert queue: two half-queue RAMs, control and result register.
//
//  channel  | beat type | direction | accepted when
//  ---------+-----------+-----------+-------------------------------
//  item     | item_t    | in        | item_valid && !item_stall
//  result   | result_t  | out       | result_valid && !result_stall
//
// An item's reads of both RAMs are issued in the cycle it is accepted and its writes follow from the
// stage register, set by the registered RAM read port; a result is loaded into the result register
// when the stage register fires and offered from the cycle after. A new item is accepted every
// cycle while item_stall is low; a read that hits the address being written is forwarded.
// Reset clears heads and counts at once; RAM contents need no clearing.
// item_stall rises only while a result waits behind a stalled result register.
module middle_insert_queue_unit
    import miq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    ram_req_t          fr_req, bk_req;
    logic [DATA_W-1:0] fr_rdata, bk_rdata;
    logic              res_ready, res_valid;
    result_t           res;
    fill_t             fill;

    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg;

    miq_ram #(.DEPTH(CAP), .WIDTH(DATA_W)) u_front_ram (
        .clk   (clk),
        .re    (fr_req.re),
        .raddr (fr_req.raddr),
        .we    (fr_req.we),
        .waddr (fr_req.waddr),
        .wdata (fr_req.wdata),
        .rdata (fr_rdata)
    );

    miq_ram #(.DEPTH(CAP), .WIDTH(DATA_W)) u_back_ram (
        .clk   (clk),
        .re    (bk_req.re),
        .raddr (bk_req.raddr),
        .we    (bk_req.we),
        .waddr (bk_req.waddr),
        .wdata (bk_req.wdata),
        .rdata (bk_rdata)
    );

    miq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .res        (res),
        .fr_req     (fr_req),
        .bk_req     (bk_req),
        .fr_rdata   (fr_rdata),
        .bk_rdata   (bk_rdata),
        .fill       (fill)
    );

    // result register: free when empty or its beat leaves this cycle
    assign res_ready = !out_valid_reg || !result_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    a_res_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_ready)
        else $error("result produced while result register is held");

    a_halves_balanced: assert property (@(posedge clk) disable iff (!rst_n)
        (fill.front == fill.back) || (fill.front == fill.back + 1'b1))
        else $error("front and back halves out of balance");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((CNT_W + 1)'(fill.front) + (CNT_W + 1)'(fill.back)) <= (CNT_W + 1)'(CAP))
        else $error("queue holds more than its capacity");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("input stalled while result side is free");

endmodule

>>> verif/middle_insert_queue_unit_tb.sv
// Self-checking testbench for the middle-insert queue: directed, fill, stall and random traffic.
module middle_insert_queue_unit_tb
    import miq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 60;
    localparam int MAX_REPORTS  = 10;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    middle_insert_queue_unit dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Queue image: front half and back half rings
    logic [DATA_W-1:0] front_ring [CAP];
    logic [DATA_W-1:0] back_ring [CAP];
    logic [IDX_W-1:0]  front_at;
    logic [IDX_W-1:0]  back_at;
    logic [CNT_W-1:0]  front_fill;
    logic [CNT_W-1:0]  back_fill;

    result_t awaited_results [$];

    int     mismatches;
    int     results_seen;
    int     cycle_count;
    int     burst_left;
    int     gap_max;
    bit     hold_request;
    int     input_stall_cycles;
    int     tail_pushes;
    int     mid_pushes;
    int     good_pops;
    int     empty_pops;
    int     full_refusals;
    int     ignored_ops;
    int     peak_fill;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [IDX_W-1:0] wrap_idx(input int base, input int off);
        return IDX_W'((base + off) % CAP);
    endfunction

    function automatic int queue_fill();
        return int'(front_fill) + int'(back_fill);
    endfunction

    // Apply one operation to the queue image; returns 1 when it yields a result
    function automatic bit predict_queue_op(input item_t op_beat, output result_t outcome);
        bit yields;
        yields  = 1'b0;
        outcome = '0;
        case (op_beat.opcode) inside
            OP_PUSH_TAIL, OP_PUSH_MID:
            begin
                if (queue_fill() >= CAP)
                begin
                    yields         = 1'b1;
                    outcome.status = ST_FULL;
                    full_refusals++;
                end
                else if (op_beat.opcode == OP_PUSH_TAIL)
                begin
                    back_ring[wrap_idx(back_at, back_fill)] = op_beat.value;
                    back_fill = back_fill + 1'b1;
                    tail_pushes++;
                end
                else
                begin
                    front_ring[wrap_idx(front_at, front_fill)] = op_beat.value;
                    front_fill = front_fill + 1'b1;
                    mid_pushes++;
                end
            end
            OP_POP:
            begin
                yields = 1'b1;
                if (front_fill == 0)
                begin
                    outcome.status = ST_EMPTY;
                    empty_pops++;
                end
                else
                begin
                    outcome.popped_value = front_ring[front_at];
                    outcome.status       = ST_OK;
                    front_at   = wrap_idx(front_at, 1);
                    front_fill = front_fill - 1'b1;
                    good_pops++;
                end
            end
            default:
            begin
                ignored_ops++;
            end
        endcase

        // Rebalance: at most one element crosses between the halves
        if (front_fill > back_fill + 1)
        begin
            back_at = wrap_idx(back_at, CAP - 1);
            back_ring[back_at] = front_ring[wrap_idx(front_at, front_fill - 1)];
            back_fill  = back_fill + 1'b1;
            front_fill = front_fill - 1'b1;
        end
        else if (front_fill < back_fill)
        begin
            front_ring[wrap_idx(front_at, front_fill)] = back_ring[back_at];
            front_fill = front_fill + 1'b1;
            back_at    = wrap_idx(back_at, 1);
            back_fill  = back_fill - 1'b1;
        end
        return yields;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic void flag_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endfunction

    // Offer one beat, with a random gap when a burst runs out, and hold it until taken
    task automatic send_item(input logic [1:0] op, input logic [DATA_W-1:0] val);
        item_t   beat;
        result_t outcome;
        int      gap;
        beat.opcode = op;
        beat.value  = val;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= beat;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        if (predict_queue_op(beat, outcome))
        begin
            awaited_results = {awaited_results, outcome};
        end
        if (queue_fill() > peak_fill)
        begin
            peak_fill = queue_fill();
        end
    endtask

    task automatic send_random_push();
        send_item($urandom_range(0, 1) ? OP_PUSH_MID : OP_PUSH_TAIL, pick_value());
    endtask

    // Empty pop, field extremes, every opcode, then drain past empty
    task automatic test_directed();
        gap_max = 0;
        send_item(OP_POP, 32'h1234_5678);
        send_item(OP_NONE, 32'hdead_beef);
        send_item(OP_PUSH_TAIL, 32'h7fff_ffff);
        send_item(OP_PUSH_MID, 32'h8000_0000);
        send_item(OP_PUSH_TAIL, 32'hffff_ffff);
        send_item(OP_PUSH_MID, 32'h0000_0000);
        send_item(OP_PUSH_TAIL, 32'h5555_5555);
        send_item(OP_PUSH_MID, 32'haaaa_aaaa);
        send_item(OP_NONE, 32'hffff_ffff);
        send_item(OP_PUSH_MID, 32'h0000_0001);
        repeat (8) send_item(OP_POP, '0);
        send_item(OP_PUSH_MID, 32'h8000_0001);
        send_item(OP_POP, 32'hffff_ffff);
    endtask

    // Fill to capacity with mixed pushes, push into the full queue, then drain it
    task automatic test_fill_and_drain();
        gap_max = 4;
        while (queue_fill() < CAP)
        begin
            send_random_push();
        end
        send_item(OP_PUSH_TAIL, pick_value());
        send_item(OP_PUSH_MID, pick_value());
        send_item(OP_NONE, pick_value());
        send_item(OP_PUSH_TAIL, pick_value());
        while (queue_fill() > 0)
        begin
            send_item(OP_POP, pick_value());
        end
        send_item(OP_POP, pick_value());
    endtask

    // Hold the result side off for a long stretch while beats keep coming
    task automatic test_backpressure();
        gap_max = 0;
        repeat (6) send_random_push();
        hold_request = 1'b1;
        repeat (12)
        begin
            send_item(OP_POP, pick_value());
            send_random_push();
        end
    endtask

    // Random traffic in phases that grow, shrink or hold the fill level
    task automatic test_random_traffic();
        int counted;
        int push_pct;
        int roll;
        counted  = 0;
        push_pct = 50;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted % 10 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: push_pct = 75;
                    1: push_pct = 25;
                    default: push_pct = 50;
                endcase
                case ($urandom_range(0, 2))
                    0: gap_max = 0;
                    1: gap_max = 3;
                    default: gap_max = 10;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                send_item(OP_NONE, pick_value());
            end
            else
            begin
                if ($urandom_range(0, 99) < push_pct)
                begin
                    send_random_push();
                end
                else
                begin
                    send_item(OP_POP, pick_value());
                end
                counted++;
            end
        end
    endtask

    // Result side: stall on random phases, or hold off once on request
    initial
    begin : result_side
        int phase_left;
        int stall_pct;
        int hold_left;
        bit hold_taken;
        phase_left   = 0;
        stall_pct    = 0;
        hold_left    = 0;
        hold_taken   = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(20, 150);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                phase_left--;
                result_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && item_valid && item_stall)
        begin
            input_stall_cycles++;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                flag_error($sformatf("unexpected result: popped_value=%h status=%0d",
                                     result.popped_value, result.status));
            end
            else
            begin
                want = awaited_results[0];
                awaited_results.delete(0);
                if (result.popped_value !== want.popped_value)
                begin
                    flag_error($sformatf("popped_value: expected %h, got %h",
                                         want.popped_value, result.popped_value));
                end
                if (result.status !== want.status)
                begin
                    flag_error($sformatf("status: expected %0d, got %0d",
                                         want.status, result.status));
                end
            end
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, awaited_results.size());
        $display("middle_insert_queue_unit regression: fail");
        $finish;
    end

    initial
    begin
        mismatches         = 0;
        results_seen       = 0;
        burst_left         = 0;
        gap_max            = 0;
        hold_request       = 1'b0;
        input_stall_cycles = 0;
        tail_pushes        = 0;
        mid_pushes         = 0;
        good_pops          = 0;
        empty_pops         = 0;
        full_refusals      = 0;
        ignored_ops        = 0;
        peak_fill          = 0;
        front_at           = '0;
        back_at            = '0;
        front_fill         = '0;
        back_fill          = '0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_drain();
        test_backpressure();
        test_random_traffic();

        item_valid <= 1'b0;
        while (awaited_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered: %0d tail pushes, %0d middle pushes, %0d pops, %0d empty pops,",
                 tail_pushes, mid_pushes, good_pops, empty_pops);
        $display("  %0d full refusals, %0d unused opcodes, peak fill %0d of %0d",
                 full_refusals, ignored_ops, peak_fill, CAP);
        $display("checked %0d results, input stalled %0d cycles, %0d mismatches",
                 results_seen, input_stall_cycles, mismatches);
        if (mismatches == 0)
        begin
            $display("middle_insert_queue_unit regression: pass");
        end
        else
        begin
            $display("middle_insert_queue_unit regression: fail");
        end
        $finish;
    end

endmodule
